// File: sv/twcr_pkg.sv
// ============================================================================
// twcr_pkg
// Shared widths, reset values, register indexes and field positions for the
// water-cling touch rejection core.
// ============================================================================
package twcr_pkg;

    // Slot count default; the top level exposes it as a parameter.
    localparam int NUM_SLOTS_DEF = 10;

    // Field widths.
    localparam int SLOT_W  = 4;
    localparam int WIDTH_W = 4;
    localparam int PRESS_W = 8;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 8;
    localparam int RATIO_W = 15;
    localparam int CLEAR_W = 16;

    // Ratio scale and the largest ratio the arithmetic can produce.
    localparam int RATIO_SCALE = 100;
    localparam int RATIO_MAX   = 25500;

    // Radix-4 restoring divider: two quotient bits per cycle.
    localparam int DIV_DIVIDEND_W = 16;
    localparam int DIV_STEPS      = DIV_DIVIDEND_W / 2;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    // Stream packing.
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    // Input tuser bits.
    localparam int SU_COMMAND = 0;
    localparam int SU_FSTART  = 1;

    // Input tdata positions (lowest bit of each field).
    localparam int SD_SLOT  = 0;
    localparam int SD_TOUCH = 4;
    localparam int SD_WAS   = 5;
    localparam int SD_WX    = 6;
    localparam int SD_WY    = 10;
    localparam int SD_PRESS = 14;
    localparam int SD_NOW   = 22;

    // Output tuser bits and tdata positions.
    localparam int MU_RECAL  = 0;
    localparam int MU_IGNORE = 1;
    localparam int MD_COUNT  = 0;
    localparam int MD_RATIO  = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_TH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_TH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_TIME  = 3'd4;

    // Register reset values.
    localparam logic               ENABLE_RST      = 1'b1;
    localparam logic [RATIO_W-1:0] RATIO_TH_RST    = 15'd100;
    localparam logic [PRESS_W-1:0] PRESSURE_TH_RST = 8'd20;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT_RST = 8'd5;
    localparam logic [CLEAR_W-1:0] CLEAR_TIME_RST  = 16'd1000;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    // One entry of the per-slot state memory.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  touchup;
    } slot_entry_t;

endpackage

// File: sv/twcr_div.sv
// ============================================================================
// twcr_div
// Restoring divider for the pressure ratio: 16-bit dividend by a nonzero
// 4-bit divisor, two quotient bits per cycle.
// ============================================================================
module twcr_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [twcr_pkg::DIV_DIVIDEND_W-1:0]    dividend,
    input  logic [twcr_pkg::WIDTH_W-1:0]           divisor,
    output logic                                   done,
    output logic [twcr_pkg::RATIO_W-1:0]           quotient
);

    localparam int DW = twcr_pkg::DIV_DIVIDEND_W;
    localparam int WW = twcr_pkg::WIDTH_W;
    localparam logic [twcr_pkg::DIV_CNT_W-1:0] LAST_STEP =
        twcr_pkg::DIV_CNT_W'(twcr_pkg::DIV_STEPS - 1);

    logic                           running_reg;
    logic [twcr_pkg::DIV_CNT_W-1:0] step_reg;
    logic [WW-1:0]                  rem_reg;
    logic [DW-1:0]                  quo_reg;
    logic [WW-1:0]                  divisor_reg;
    logic [WW+DW-1:0]               stage1;
    logic [WW+DW-1:0]               stage2;

    // One restoring step: shift the next dividend bit into the remainder and
    // shift the quotient bit in at the bottom of the same word.
    function automatic logic [WW+DW-1:0] div_step(
        input logic [WW-1:0] rem,
        input logic [DW-1:0] quo,
        input logic [WW-1:0] d
    );
        logic [WW:0]   rw;
        logic [WW:0]   diff;
        logic          ge;
        logic [WW-1:0] nrem;
        rw   = {rem, quo[DW-1]};
        diff = rw - {1'b0, d};
        ge   = (rw >= {1'b0, d});
        nrem = ge ? diff[WW-1:0] : rw[WW-1:0];
        return {nrem, quo[DW-2:0], ge};
    endfunction

    assign stage1 = div_step(rem_reg, quo_reg, divisor_reg);
    assign stage2 = div_step(stage1[WW+DW-1:DW], stage1[DW-1:0], divisor_reg);

    assign done     = running_reg && (step_reg == LAST_STEP);
    assign quotient = quo_reg[twcr_pkg::RATIO_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            step_reg    <= '0;
        end else if (start) begin
            running_reg <= 1'b1;
            step_reg    <= '0;
        end else if (running_reg) begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                running_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end else if (running_reg) begin
            rem_reg <= stage2[WW+DW-1:DW];
            quo_reg <= stage2[DW-1:0];
        end
    end

endmodule

// File: sv/touch_water_cling_reject_core.sv
// ============================================================================
// touch_water_cling_reject_core
// Water-cling rejection filter for a capacitive touch panel: per-slot miss
// counting with a recalibration request and frame suppression.
// ============================================================================
//
// Channel   Direction  Handshake              Contents
// s_*       in         s_tvalid / s_tready    one finger report or clear command
// m_*       out        m_tvalid / m_tready    one result per input transaction
// cfg_*     in         cfg_valid / cfg_ready  register write (index, data)
//
// A finger report occupies the block until it is judged, so reports are
// accepted only while the sequencer is idle: the acceptance cycle reads the slot
// memory and starts the divider, the radix-4 divider then forms
// pressure*100/width, and the judging cycle judges the report, writes the slot
// back and loads the result register.
// A clear command skips the divider and goes from acceptance straight to judging.
// Reset (aresetn low, synchronous) restores the register defaults, clears the
// per-slot valid bits so every slot reads as zero, and empties the result
// register. No clearing pass is needed.
// When the result register is still full, the judging cycle waits for m_tready.
//
module touch_water_cling_reject_core #(
    parameter int NUM_SLOTS = twcr_pkg::NUM_SLOTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // Input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [3:0] finger_slot, [4] touching, [5] was_touching, [9:6] width_x,
    // [13:10] width_y, [21:14] pressure, [53:22] now_ms, [55:54] zero
    input  logic [twcr_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] command, [1] frame_start
    input  logic [twcr_pkg::S_TUSER_W-1:0]     s_tuser,

    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] slot_count, [22:8] ratio, [23] zero
    output logic [twcr_pkg::M_TDATA_W-1:0]     m_tdata,
    // [0] recalibrate, [1] ignored
    output logic [twcr_pkg::M_TUSER_W-1:0]     m_tuser,

    // Configuration writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [twcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [twcr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_W     = twcr_pkg::SLOT_W;
    localparam int WIDTH_W    = twcr_pkg::WIDTH_W;
    localparam int PRESS_W    = twcr_pkg::PRESS_W;
    localparam int TIME_W     = twcr_pkg::TIME_W;
    localparam int COUNT_W    = twcr_pkg::COUNT_W;
    localparam int RATIO_W    = twcr_pkg::RATIO_W;
    localparam int CLEAR_W    = twcr_pkg::CLEAR_W;
    localparam int DW         = twcr_pkg::DIV_DIVIDEND_W;

    // Control sequencer. Only one report is in flight, so the memory read at
    // acceptance can never overlap the write-back of an earlier report.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EVAL = 3'b100
    } state_t;

    // Fields of the report in flight.
    typedef struct packed {
        logic                  command;
        logic                  fstart;
        logic                  in_range;
        logic [SLOT_IDX_W-1:0] slot_idx;
        logic                  touching;
        logic                  was_touching;
        logic [PRESS_W-1:0]    pressure;
        logic [TIME_W-1:0]     now_ms;
    } item_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers.
    logic               enable_reg;
    logic [RATIO_W-1:0] ratio_th_reg;
    logic [PRESS_W-1:0] pressure_th_reg;
    logic [COUNT_W-1:0] count_limit_reg;
    logic [CLEAR_W-1:0] clear_time_reg;

    // Slot memory with one valid bit per entry; an entry that is not valid
    // reads as zero, which lets reset and a trigger clear every slot at once.
    twcr_pkg::slot_entry_t mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  valid_reg;
    twcr_pkg::slot_entry_t rd_entry_reg;
    logic                  rd_valid_reg;

    logic                  frame_supp_reg;
    item_t                 item_reg;

    logic                         m_tvalid_reg;
    logic [twcr_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [twcr_pkg::M_TUSER_W-1:0] m_tuser_reg;

    // Input decode.
    logic                  s_accept;
    logic                  s_command;
    logic [SLOT_W-1:0]     s_slot;
    logic [WIDTH_W-1:0]    s_wx;
    logic [WIDTH_W-1:0]    s_wy;
    logic [WIDTH_W-1:0]    s_wmax;
    logic [WIDTH_W-1:0]    s_divisor;
    logic [PRESS_W-1:0]    s_pressure;
    logic                  s_in_range;
    logic [SLOT_IDX_W-1:0] rd_addr;
    logic [DW-1:0]         s_dividend;

    // Divider.
    logic                  div_start;
    logic                  div_done;
    logic [RATIO_W-1:0]    ratio;

    // Judging.
    logic                  out_load;
    logic [COUNT_W-1:0]    cur_count;
    logic [TIME_W-1:0]     cur_time;
    logic [TIME_W-1:0]     age_diff;
    logic                  suspicious;
    logic [COUNT_W-1:0]    count_a;
    logic [COUNT_W-1:0]    count_b;
    logic                  trigger;
    logic                  supp_eff;
    logic                  wr_en;
    twcr_pkg::slot_entry_t wr_entry;
    logic                  clear_all;
    logic                  supp_set;
    logic                  res_recal;
    logic                  res_ignore;
    logic [COUNT_W-1:0]    res_count;
    logic [RATIO_W-1:0]    res_ratio;

    // ------------------------------------------------------------------
    // Input side: take a new transaction only when the sequencer is idle.
    // ------------------------------------------------------------------
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign s_command  = s_tuser[twcr_pkg::SU_COMMAND];
    assign s_slot     = s_tdata[twcr_pkg::SD_SLOT +: SLOT_W];
    assign s_wx       = s_tdata[twcr_pkg::SD_WX +: WIDTH_W];
    assign s_wy       = s_tdata[twcr_pkg::SD_WY +: WIDTH_W];
    assign s_pressure = s_tdata[twcr_pkg::SD_PRESS +: PRESS_W];
    assign s_wmax     = (s_wx >= s_wy) ? s_wx : s_wy;
    // A zero width divides by one.
    assign s_divisor  = (s_wmax == '0) ? WIDTH_W'(1) : s_wmax;
    assign s_dividend = DW'(s_pressure) * DW'(twcr_pkg::RATIO_SCALE);
    assign s_in_range = ({1'b0, s_slot} < (SLOT_W + 1)'(NUM_SLOTS));
    assign rd_addr    = s_in_range ? s_slot[SLOT_IDX_W-1:0] : '0;

    // A clear command needs no ratio, so it goes straight to judging.
    assign div_start  = s_accept && !s_command;

    twcr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_dividend),
        .divisor  (s_divisor),
        .done     (div_done),
        .quotient (ratio)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.command      <= s_command;
            item_reg.fstart       <= s_tuser[twcr_pkg::SU_FSTART];
            item_reg.in_range     <= s_in_range;
            item_reg.slot_idx     <= rd_addr;
            item_reg.touching     <= s_tdata[twcr_pkg::SD_TOUCH];
            item_reg.was_touching <= s_tdata[twcr_pkg::SD_WAS];
            item_reg.pressure     <= s_pressure;
            item_reg.now_ms       <= s_tdata[twcr_pkg::SD_NOW +: TIME_W];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = s_command ? ST_EVAL : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Judging: runs in the cycle the result register can take the result.
    // ------------------------------------------------------------------
    assign out_load = (state_reg == ST_EVAL) && (!m_tvalid_reg || m_tready);

    assign cur_count  = rd_valid_reg ? rd_entry_reg.count   : '0;
    assign cur_time   = rd_valid_reg ? rd_entry_reg.touchup : '0;
    // Frame start releases suppression before the report is judged.
    assign supp_eff   = item_reg.fstart ? 1'b0 : frame_supp_reg;
    assign suspicious = (ratio <= ratio_th_reg) || (item_reg.pressure <= pressure_th_reg);
    // Wrapping time compare: the touch-up is old once this difference is negative.
    assign age_diff   = cur_time + TIME_W'(clear_time_reg) - item_reg.now_ms;
    assign count_a    = (!item_reg.was_touching && (cur_count != '0) && age_diff[TIME_W-1])
                        ? '0 : cur_count;
    assign count_b    = !suspicious ? count_a
                      : (count_a == twcr_pkg::COUNT_MAX) ? count_a : count_a + 1'b1;
    assign trigger    = suspicious && (count_b >= count_limit_reg);

    always_comb begin
        wr_en      = 1'b0;
        wr_entry   = '{count: cur_count, touchup: cur_time};
        clear_all  = 1'b0;
        supp_set   = 1'b0;
        res_recal  = 1'b0;
        res_ignore = 1'b0;
        res_count  = '0;
        res_ratio  = ratio;
        if (item_reg.command) begin
            clear_all = 1'b1;
            res_ratio = '0;
        end else if (!item_reg.in_range) begin
            res_count = '0;
        end else if (!enable_reg) begin
            res_count = cur_count;
        end else if (supp_eff) begin
            res_ignore = 1'b1;
            res_count  = cur_count;
        end else if (!item_reg.touching) begin
            res_count = cur_count;
            if (item_reg.was_touching) begin
                // Touch-up: remember when the finger lifted.
                wr_en            = 1'b1;
                wr_entry.touchup = item_reg.now_ms;
            end
        end else if (trigger) begin
            clear_all = 1'b1;
            supp_set  = 1'b1;
            res_recal = 1'b1;
        end else begin
            wr_en          = 1'b1;
            wr_entry.count = count_b;
            res_count      = count_b;
        end
    end

    // ------------------------------------------------------------------
    // Slot memory: read at acceptance, written back in the judging cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (out_load && wr_en) begin
            mem[item_reg.slot_idx] <= wr_entry;
        end
        if (s_accept) begin
            rd_entry_reg <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (out_load && clear_all) begin
            valid_reg <= '0;
        end else if (out_load && wr_en) begin
            valid_reg[item_reg.slot_idx] <= 1'b1;
        end
    end

    // Frame suppression; a clear command leaves it as it is.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_supp_reg <= 1'b0;
        end else if (out_load && !item_reg.command) begin
            frame_supp_reg <= supp_set || supp_eff;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // The ratio sits above the count; the top bit of tdata stays zero.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= twcr_pkg::M_TDATA_W'({res_ratio, res_count});
            m_tuser_reg <= {res_ignore, res_recal};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // Configuration registers; writes to unknown indexes are dropped.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= twcr_pkg::ENABLE_RST;
            ratio_th_reg    <= twcr_pkg::RATIO_TH_RST;
            pressure_th_reg <= twcr_pkg::PRESSURE_TH_RST;
            count_limit_reg <= twcr_pkg::COUNT_LIMIT_RST;
            clear_time_reg  <= twcr_pkg::CLEAR_TIME_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                twcr_pkg::REG_ENABLE:      enable_reg      <= cfg_data[0];
                twcr_pkg::REG_RATIO_TH:    ratio_th_reg    <= cfg_data[RATIO_W-1:0];
                twcr_pkg::REG_PRESSURE_TH: pressure_th_reg <= cfg_data[PRESS_W-1:0];
                twcr_pkg::REG_COUNT_LIMIT: count_limit_reg <= cfg_data[COUNT_W-1:0];
                twcr_pkg::REG_CLEAR_TIME:  clear_time_reg  <= cfg_data[CLEAR_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: sv/twcr_checker.sv
// ============================================================================
// twcr_checker
// Port-level checks on the result stream of the water-cling rejection core.
// ============================================================================
module twcr_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [twcr_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [twcr_pkg::M_TUSER_W-1:0]    m_tuser
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A skipped report never also requests recalibration.
    a_recal_not_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[twcr_pkg::MU_RECAL] && m_tuser[twcr_pkg::MU_IGNORE]))
        else $error("recalibrate and ignored both set");

    // A trigger clears the reported slot's count.
    a_recal_zero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[twcr_pkg::MU_RECAL]
            |-> m_tdata[twcr_pkg::MD_COUNT +: twcr_pkg::COUNT_W] == '0)
        else $error("nonzero count on recalibration");

    // The divider never yields more than full pressure over unit width.
    a_ratio_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[twcr_pkg::MD_RATIO +: twcr_pkg::RATIO_W]
            <= twcr_pkg::RATIO_W'(twcr_pkg::RATIO_MAX))
        else $error("ratio out of range");

endmodule

bind touch_water_cling_reject_core twcr_checker u_twcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
